// ===== src/assert_macros.svh =====
// Assertion macros shared by the timer core RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication that must hold on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/dit_pkg.sv =====
// Shared types and constants for the dual interval timer core.
// No dependencies; imported by the front, queue, back and top modules.
package dit_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register addresses on the bus side.
    localparam logic [3:0] ADDR_TA_LO = 4'h4;
    localparam logic [3:0] ADDR_TA_HI = 4'h5;
    localparam logic [3:0] ADDR_TB_LO = 4'h6;
    localparam logic [3:0] ADDR_TB_HI = 4'h7;
    localparam logic [3:0] ADDR_ICR   = 4'hD;
    localparam logic [3:0] ADDR_CRA   = 4'hE;
    localparam logic [3:0] ADDR_CRB   = 4'hF;

    // Control register bits.
    localparam logic [7:0] CTL_ENABLE   = 8'h01;
    localparam logic [7:0] CTL_ONESHOT  = 8'h08;
    localparam logic [7:0] CTL_STROBE   = 8'h10;
    localparam logic [7:0] CTL_A_CNT    = 8'h20;
    localparam logic [7:0] CTL_B_FROM_A = 8'h40;

    // Interrupt register bits.
    localparam logic [7:0] FLAG_IRQ  = 8'h80;
    localparam logic [4:0] MASK_BITS = 5'h1F;

    // Operation class decided by the front end.
    typedef enum logic [1:0] {
        OP_NOP,
        OP_TICK,
        OP_WRITE,
        OP_READ
    } op_t;

    // Decoded register target.
    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_TA_LO,
        SEL_TA_HI,
        SEL_TB_LO,
        SEL_TB_HI,
        SEL_ICR,
        SEL_CRA,
        SEL_CRB
    } reg_sel_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        op_t        op;
        logic [6:0] cycles;
        reg_sel_t   sel;
        logic [7:0] data;
    } item_t;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

// ===== src/dit_front.sv =====
// Front end: input handshake and classification of items into queue entries.
// Depends on dit_pkg.
module dit_front
    import dit_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [6:0] tick_cycles,
    input  logic [3:0] reg_addr,
    input  logic [7:0] write_data,
    input  q_status_t  q_status,
    output logic       push,
    output item_t      push_item
);

    op_t      op;
    reg_sel_t sel;

    // Accept whenever the queue has room.
    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // Classify the command.
    always_comb
    begin
        case (command)
            CMD_TICK:  op = OP_TICK;
            CMD_WRITE: op = OP_WRITE;
            CMD_READ:  op = OP_READ;
            default:   op = OP_NOP;
        endcase
    end

    // Decode the register address; unmapped registers are ignored later.
    always_comb
    begin
        case (reg_addr)
            ADDR_TA_LO: sel = SEL_TA_LO;
            ADDR_TA_HI: sel = SEL_TA_HI;
            ADDR_TB_LO: sel = SEL_TB_LO;
            ADDR_TB_HI: sel = SEL_TB_HI;
            ADDR_ICR:   sel = SEL_ICR;
            ADDR_CRA:   sel = SEL_CRA;
            ADDR_CRB:   sel = SEL_CRB;
            default:    sel = SEL_NONE;
        endcase
    end

    assign push_item.op     = op;
    assign push_item.cycles = tick_cycles;
    assign push_item.sel    = sel;
    assign push_item.data   = write_data;

endmodule

// ===== src/dit_queue.sv =====
// Short FIFO of classified items between the front and back ends.
// Depends on dit_pkg.
module dit_queue
    import dit_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      push_item,
    input  logic                       pop,
    output item_t                      pop_item,
    output q_status_t                  q_status,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
        if (ptr == PW'(DEPTH - 1))
            return '0;
        else
            return ptr + 1'b1;
    endfunction

    // Entry storage, written only on a push.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= next_ptr(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= next_ptr(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign pop_item       = entry_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign count          = count_reg;

endmodule

// ===== src/dit_back.sv =====
// Back end: timer and interrupt state, item execution and the result register.
// Depends on dit_pkg.
module dit_back
    import dit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  item_t      pop_item,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       irq
);

    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  ctl;
        logic        uflow;
    } timer_res_t;

    logic [15:0] latch_a_reg, latch_a_next;
    logic [15:0] latch_b_reg, latch_b_next;
    logic [15:0] count_a_reg, count_a_next;
    logic [15:0] count_b_reg, count_b_next;
    logic [7:0]  control_a_reg, control_a_next;
    logic [7:0]  control_b_reg, control_b_next;
    logic [4:0]  irq_mask_reg, irq_mask_next;
    logic [7:0]  irq_flags_reg, irq_flags_next;
    logic        out_valid_reg;
    logic [7:0]  read_data_reg, read_data_next;
    logic        irq_reg;
    timer_res_t  res_a;
    timer_res_t  res_b;

    // One timer step: strobe load, or count down with reload on underflow.
    function automatic timer_res_t run_timer(
        input logic [15:0] count,
        input logic [15:0] latch,
        input logic [7:0]  ctl,
        input logic [7:0]  gate,
        input logic [6:0]  cycles
    );
        timer_res_t  r;
        logic [16:0] diff;
        r.count = count;
        r.ctl   = ctl;
        r.uflow = 1'b0;
        diff    = {1'b0, count} - {10'b0, cycles};
        if ((ctl & CTL_STROBE) != 8'h00)
        begin
            r.count = latch;
        end
        else if ((ctl & (CTL_ENABLE | gate)) == CTL_ENABLE)
        begin
            if (count <= {9'b0, cycles})
            begin
                r.uflow = 1'b1;
                r.count = diff[15:0] + latch;
                if ((ctl & CTL_ONESHOT) != 8'h00)
                    r.ctl = r.ctl & ~CTL_ENABLE;
            end
            else
            begin
                r.count = diff[15:0];
            end
        end
        r.ctl = r.ctl & ~CTL_STROBE;
        return r;
    endfunction

    // Take the next item whenever the result register is free or being emptied.
    assign pop = q_status.valid && (!out_valid_reg || out_ready);

    assign res_a = run_timer(count_a_reg, latch_a_reg, control_a_reg, CTL_A_CNT,
                             pop_item.cycles);
    assign res_b = run_timer(count_b_reg, latch_b_reg, control_b_reg, CTL_B_FROM_A,
                             pop_item.cycles);

    // Execute the item at the head of the queue.
    always_comb
    begin
        latch_a_next   = latch_a_reg;
        latch_b_next   = latch_b_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        control_a_next = control_a_reg;
        control_b_next = control_b_reg;
        irq_mask_next  = irq_mask_reg;
        irq_flags_next = irq_flags_reg;
        read_data_next = 8'h00;
        case (pop_item.op)
            OP_TICK:
            begin
                count_a_next   = res_a.count;
                control_a_next = res_a.ctl;
                count_b_next   = res_b.count;
                control_b_next = res_b.ctl;
                irq_flags_next = irq_flags_reg | {6'b0, res_b.uflow, res_a.uflow};
                if ((res_a.uflow && irq_mask_reg[0]) || (res_b.uflow && irq_mask_reg[1]))
                    irq_flags_next = irq_flags_next | FLAG_IRQ;
            end
            OP_WRITE:
            begin
                case (pop_item.sel)
                    SEL_TA_LO: latch_a_next[7:0]  = pop_item.data;
                    SEL_TA_HI: latch_a_next[15:8] = pop_item.data;
                    SEL_TB_LO: latch_b_next[7:0]  = pop_item.data;
                    SEL_TB_HI: latch_b_next[15:8] = pop_item.data;
                    SEL_ICR:
                    begin
                        if ((pop_item.data & FLAG_IRQ) != 8'h00)
                            irq_mask_next = irq_mask_reg | (pop_item.data[4:0] & MASK_BITS);
                        else
                            irq_mask_next = irq_mask_reg & ~(pop_item.data[4:0] & MASK_BITS);
                    end
                    SEL_CRA:   control_a_next = pop_item.data;
                    SEL_CRB:   control_b_next = pop_item.data;
                    default:   ;
                endcase
            end
            OP_READ:
            begin
                case (pop_item.sel)
                    SEL_TA_LO: read_data_next = count_a_reg[7:0];
                    SEL_TA_HI: read_data_next = count_a_reg[15:8];
                    SEL_TB_LO: read_data_next = count_b_reg[7:0];
                    SEL_TB_HI: read_data_next = count_b_reg[15:8];
                    SEL_ICR:
                    begin
                        read_data_next = irq_flags_reg;
                        irq_flags_next = 8'h00;
                    end
                    SEL_CRA:   read_data_next = control_a_reg;
                    SEL_CRB:   read_data_next = control_b_reg;
                    default:   read_data_next = 8'h00;
                endcase
            end
            default: ;
        endcase
    end

    // Architectural state, updated only when an item is executed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_a_reg   <= '0;
            latch_b_reg   <= '0;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            control_a_reg <= '0;
            control_b_reg <= '0;
            irq_mask_reg  <= '0;
            irq_flags_reg <= '0;
        end
        else if (pop)
        begin
            latch_a_reg   <= latch_a_next;
            latch_b_reg   <= latch_b_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            control_a_reg <= control_a_next;
            control_b_reg <= control_b_next;
            irq_mask_reg  <= irq_mask_next;
            irq_flags_reg <= irq_flags_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_flags_next[7];
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq       = irq_reg;

endmodule

// ===== src/dual_interval_timer_irq_core.sv =====
// Dual 16-bit interval timer core with interrupt flags and mask.
// An accepted item is written into a queue entry, then popped and executed by the back end into the result register.
// Throughput: one item per cycle while out_ready keeps the result register free; a held result stalls the back end.
// The queue of QUEUE_DEPTH entries lets input and output stall independently.
// Reset (rst_n, asynchronous) clears timers, latches, control, mask, flags and the queue.
// Depends on dit_pkg, dit_front, dit_queue, dit_back and assert_macros.svh.
`include "assert_macros.svh"

module dual_interval_timer_irq_core
    import dit_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [6:0] tick_cycles,
    input  logic [3:0] reg_addr,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       irq
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    q_status_t     q_status;
    logic          push;
    logic          pop;
    item_t         push_item;
    item_t         pop_item;
    logic [CW-1:0] q_count;

    // Front end: handshake and classification.
    dit_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .tick_cycles (tick_cycles),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    // Decoupling queue.
    dit_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status),
        .count     (q_count)
    );

    // Back end: execution and result register.
    dit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .irq       (irq)
    );

    // The queue never holds more items than it has entries.
    `ASSERT_ALWAYS(a_q_bound, clk, rst_n, q_count <= CW'(QUEUE_DEPTH), "queue overfilled")

    // A push without a pop grows the fill count by exactly one.
    `ASSERT_NEXT(a_q_grow, clk, rst_n, push && !pop, q_count == $past(q_count) + 1'b1, "count slip")

    // An executed item always leaves a result waiting in the next cycle.
    `ASSERT_NEXT(a_pop_result, clk, rst_n, pop, out_valid, "executed item produced no result")

endmodule
